// ----- design/assert_macros.svh -----
// Assertion macros shared by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, disabled while reset is asserted.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tcw_pkg.sv -----
// Shared types and constants for the text console cursor writer.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 11;

    localparam logic [CHAR_W-1:0]  CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CODE_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0]  CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE     = 8'h20;
    localparam int                 TAB_STEP       = 4;
    localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h07;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

    // Output stream packing
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic               we;
        logic [POS_W-1:0]   idx;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
    } t_result;

endpackage

// ----- design/tcw_step.sv -----
// Cursor update and cell write decode for one character code.
module tcw_step #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic [tcw_pkg::CHAR_W-1:0]  i_code,
    input  logic [tcw_pkg::COLOR_W-1:0] i_color,
    input  logic [$clog2(ROWS)-1:0]     i_row,
    input  logic [$clog2(COLUMNS)-1:0]  i_col,
    output logic [$clog2(ROWS)-1:0]     o_row,
    output logic [$clog2(COLUMNS)-1:0]  o_col,
    output tcw_pkg::t_result            o_result
);
    import tcw_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int LIN_W = $clog2(ROWS * COLUMNS);

    logic [COL_W:0]   col_adv;
    logic [COL_W:0]   col_tab;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W-1:0] row_wrap;
    logic [ROW_W-1:0] wr_row;
    logic [COL_W-1:0] wr_col;
    logic [LIN_W-1:0] wr_lin;
    logic [LIN_W-1:0] cur_lin;
    logic             wr_en;
    logic [VALUE_W-1:0] wr_val;

    assign col_adv  = {1'b0, i_col} + (COL_W+1)'(1);
    assign col_tab  = {1'b0, i_col} + (COL_W+1)'(TAB_STEP);
    assign row_inc  = {1'b0, i_row} + (ROW_W+1)'(1);
    assign row_wrap = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];

    always_comb begin
        o_row  = i_row;
        o_col  = i_col;
        wr_row = i_row;
        wr_col = i_col;
        wr_en  = 1'b0;
        wr_val = '0;
        case (i_code)
            CODE_NEWLINE: begin
                o_row = row_wrap;
                o_col = '0;
            end
            CODE_BACKSPACE: begin
                // at the origin nothing moves and nothing is written
                if (i_col != '0) begin
                    o_col = i_col - COL_W'(1);
                    wr_en = 1'b1;
                end else if (i_row != '0) begin
                    o_row = i_row - ROW_W'(1);
                    o_col = COL_W'(COLUMNS - 1);
                    wr_en = 1'b1;
                end
                wr_row = o_row;
                wr_col = o_col;
                if (wr_en) begin
                    wr_val = {i_color, BLANK_CODE};
                end
            end
            CODE_TAB: begin
                if (col_tab >= (COL_W+1)'(COLUMNS)) begin
                    o_row = row_wrap;
                    o_col = '0;
                end else begin
                    o_col = col_tab[COL_W-1:0];
                end
            end
            default: begin
                wr_en  = 1'b1;
                wr_val = {i_color, i_code};
                if (col_adv >= (COL_W+1)'(COLUMNS)) begin
                    o_row = row_wrap;
                    o_col = '0;
                end else begin
                    o_col = col_adv[COL_W-1:0];
                end
            end
        endcase
    end

    assign wr_lin  = LIN_W'(wr_row) * LIN_W'(COLUMNS) + LIN_W'(wr_col);
    assign cur_lin = LIN_W'(o_row) * LIN_W'(COLUMNS) + LIN_W'(o_col);

    // field order: we, idx, val, pos
    assign o_result = {wr_en, (wr_en ? POS_W'(wr_lin) : POS_W'(0)), wr_val, POS_W'(cur_lin)};

endmodule

// ----- design/text_console_cursor_writer_top.sv -----
// Text console cursor writer: top level with stream ports and APB register.
//
// Input stream (s_axis): one character code per transfer in tdata[7:0].
// Codes 10, 8 and 9 are newline, backspace and tab; any other code is written
// to the cell under the cursor with the current attribute byte.
// Output stream (m_axis): exactly one result per input transfer, in order.
// tuser carries the cell write enable; tdata carries the cell address, the
// 16-bit cell value and the cursor position after the character.
// APB: register 0 at address 0 holds the attribute byte (reset 0x07).
// From an input transfer to result valid, the input register captures the
// code, and the result register then loads through the cursor update logic.
// Throughput is one character per cycle while the receiver does not stall;
// the cursor row/column registers close their loop through the update logic.
// Reset (synchronous, active low) empties both stages and puts the cursor
// at row 0, column 0. When the receiver stalls, the result register holds;
// one more character waits in the input register, then s_axis_tready drops.
module text_console_cursor_writer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: char_code[7:0]
    input  logic [tcw_pkg::CHAR_W-1:0]         s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: cell_index[10:0], cell_value[26:11], cursor_position[37:27], zero[39:38]
    output logic [tcw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: write_enable[0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import tcw_pkg::*;

    `include "assert_macros.svh"

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);

    logic [COLOR_W-1:0] r_color;
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_code;
    logic               r_out_valid;
    t_result            r_out;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;

    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    t_result            n_out;
    logic               adv;
    logic               cfg_wr;
    logic               reg_sel;

    // APB register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_TEXT_COLOR);
    assign cfg_wr  = psel && penable && pwrite && reg_sel;
    assign prdata  = reg_sel ? APB_DATA_W'(r_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (cfg_wr) begin
            r_color <= pwdata[COLOR_W-1:0];
        end
    end

    // Two-stage pipe: input register, then result register
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_code <= s_axis_tdata;
        end
    end

    tcw_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .i_code   (r_in_code),
        .i_color  (r_color),
        .i_row    (r_row),
        .i_col    (r_col),
        .o_row    (n_row),
        .o_col    (n_col),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.we;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.pos, r_out.val, r_out.idx});

    // Checks
    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n,
        (r_row < ROW_W'(ROWS - 1)) || (r_row == ROW_W'(ROWS - 1)),
        "cursor row out of range")
    `TCW_ASSERT(a_col_range, i_clk, i_rst_n,
        (r_col < COL_W'(COLUMNS - 1)) || (r_col == COL_W'(COLUMNS - 1)),
        "cursor column out of range")
    `TCW_ASSERT(a_nowrite_zero, i_clk, i_rst_n,
        (r_out_valid && !r_out.we) |-> (r_out.idx == '0 && r_out.val == '0),
        "result without cell write carries nonzero cell fields")
    `TCW_ASSERT(a_cursor_hold, i_clk, i_rst_n,
        !adv |=> ($stable(r_row) && $stable(r_col)),
        "cursor moved without a character transfer")

endmodule
